### rtl/odo_pkg.sv
// Shared types, constants and arithmetic helpers for the tracking wheel odometry block.
package odo_pkg;

	localparam int CORDIC_ITERS = 16;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// Angle scaling: pi in Q30 split as 36000 * ANG_Q + ANG_R, so that
	// round(a * pi / 36000) = a * ANG_Q + floor((a * ANG_R + ANG_RND) / 36000).
	// The small quotient uses a reciprocal multiply, exact below 2^29.
	localparam logic signed [33:0] ANG_Q   = 34'sd93701;
	localparam logic signed [33:0] ANG_R   = 34'sd23426;
	localparam logic signed [33:0] ANG_M   = 34'sd977343670;
	localparam logic [28:0]        ANG_RND = 29'd18000;

	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
		32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef enum logic [2:0] {
		CFG_START_X,
		CFG_START_Y,
		CFG_START_HEADING,
		CFG_PARALLEL_SCALE,
		CFG_PERP_SCALE,
		CFG_PARALLEL_OFFSET,
		CFG_PERP_OFFSET
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] parallel_ticks;
		logic signed [31:0] perp_ticks;
		logic [15:0]        gyro_heading;
	} odo_in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading_out;
	} odo_out_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [15:0] start_heading;
		logic [23:0]        parallel_scale;
		logic [23:0]        perp_scale;
		logic [22:0]        parallel_offset;
		logic [22:0]        perp_offset;
	} odo_cfg_t;

	// Classified sample handed from the front end to the back end
	typedef struct packed {
		logic signed [31:0] d_par;
		logic signed [31:0] d_perp;
		logic signed [15:0] dh;
		logic signed [15:0] head;
		logic               turn;
	} odo_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PAR, ST_PERP, ST_HREM, ST_HREC, ST_HWHOLE, ST_HSTART, ST_HCOR,
		ST_RWAIT,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
		ST_AREM, ST_AREC, ST_AWHOLE, ST_ASTART, ST_ACOR,
		ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_OUT
	} odo_state_t;

	// Shift right with round half up (floor of biased value)
	function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
		input int sh);
		logic signed [67:0] bias;
		bias = 68'sd1 <<< (sh - 1);
		return (v + bias) >>> sh;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [33:0] abs34(input logic signed [33:0] v);
		logic signed [33:0] n;
		n = -v;
		return v[33] ? n : v;
	endfunction

endpackage

### rtl/tracking_wheel_odometry_top.sv
// Top level of the tracking wheel odometry block: configuration, front end, queue, back end.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   odo_in_t  (wheel ticks, gyro)
//   out      source     out_valid / out_stall odo_out_t (position, heading)
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item with a heading change takes two passes of the one-step-per-cycle CORDIC in the
// back end and, on that turn, the divider for the sine ratio; one without takes a single
// pass. The front end takes an item every cycle until the two-entry queue fills.
// Reset clears the previous sample, the displacement and all handshake state, and
// loads the configuration defaults. A stalled output holds its item in the output
// register while the back end finishes the next one.
module tracking_wheel_odometry_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  odo_pkg::odo_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output odo_pkg::odo_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import odo_pkg::*;

	odo_cfg_t  cfg_q;
	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_valid;
	odo_item_t push_item;
	odo_item_t q_item;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x         <= '0;
			cfg_q.start_y         <= '0;
			cfg_q.start_heading   <= '0;
			cfg_q.parallel_scale  <= 24'd475825;
			cfg_q.perp_scale      <= 24'd406287;
			cfg_q.parallel_offset <= 23'd360448;
			cfg_q.perp_offset     <= 23'd327680;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_X:         cfg_q.start_x <= cfg_data;
				CFG_START_Y:         cfg_q.start_y <= cfg_data;
				CFG_START_HEADING:   cfg_q.start_heading <= cfg_data[15:0];
				CFG_PARALLEL_SCALE:  cfg_q.parallel_scale <= cfg_data[23:0];
				CFG_PERP_SCALE:      cfg_q.perp_scale <= cfg_data[23:0];
				CFG_PARALLEL_OFFSET: cfg_q.parallel_offset <= cfg_data[22:0];
				CFG_PERP_OFFSET:     cfg_q.perp_offset <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

	odo_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.start_heading (cfg_q.start_heading),
		.push          (q_push),
		.push_item     (push_item),
		.full          (q_full)
	);

	odo_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.item      (q_item)
	);

	odo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// Back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// Front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue pushed while full");

	// A presented heading is always wrapped
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.heading_out >= -16'sd18000 &&
			out_data.heading_out <= 16'sd17999))
		else $error("heading out of range");
`endif
endmodule

### rtl/odo_queue.sv
// Two-entry queue carrying classified items from the front end to the back end.
module odo_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  odo_pkg::odo_item_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output odo_pkg::odo_item_t item
);
	import odo_pkg::*;

	odo_item_t  mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign item  = mem_q[rd_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

### rtl/odo_front.sv
// Front end: accepts samples, forms wheel and heading deltas and classifies turns.
module odo_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  odo_pkg::odo_in_t   in_data,
	input  logic signed [15:0] start_heading,
	output logic               push,
	output odo_pkg::odo_item_t push_item,
	input  logic               full
);
	import odo_pkg::*;

	logic [31:0]        par_prev_q;
	logic [31:0]        perp_prev_q;
	logic [15:0]        head_prev_q;
	logic [15:0]        g;
	logic signed [17:0] diff;
	logic signed [17:0] dh_w;
	logic signed [17:0] sum;
	logic signed [17:0] sum_r;
	logic signed [17:0] head_w;

	assign in_stall = full;
	assign push     = in_valid && !full;

	// Reduce gyro and wrap the heading delta and absolute heading
	always_comb begin
		g = (in_data.gyro_heading >= 16'd36000) ? in_data.gyro_heading - 16'd36000
			: in_data.gyro_heading;
		diff = $signed({2'b00, g}) - $signed({2'b00, head_prev_q});
		if (diff < -18'sd18000) begin
			dh_w = diff + 18'sd36000;
		end else if (diff >= 18'sd18000) begin
			dh_w = diff - 18'sd36000;
		end else begin
			dh_w = diff;
		end
		sum = $signed({2'b00, g}) + 18'(start_heading);
		if (sum < 18'sd0) begin
			sum_r = sum + 18'sd36000;
		end else if (sum >= 18'sd36000) begin
			sum_r = sum - 18'sd36000;
		end else begin
			sum_r = sum;
		end
		head_w = (sum_r >= 18'sd18000) ? sum_r - 18'sd36000 : sum_r;
	end

	// Build the item
	always_comb begin
		push_item.d_par  = $signed(in_data.parallel_ticks - par_prev_q);
		push_item.d_perp = $signed(in_data.perp_ticks - perp_prev_q);
		push_item.dh     = dh_w[15:0];
		push_item.head   = head_w[15:0];
		push_item.turn   = (dh_w != 18'sd0);
	end

	// Hold the previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_prev_q  <= '0;
			perp_prev_q <= '0;
			head_prev_q <= '0;
		end else if (push) begin
			par_prev_q  <= in_data.parallel_ticks;
			perp_prev_q <= in_data.perp_ticks;
			head_prev_q <= g;
		end
	end
endmodule

### rtl/odo_div.sv
// Unsigned 64 by 32 bit restoring divider, two quotient bits per cycle.
module odo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	input  logic [31:0] d,
	output logic [63:0] q,
	output logic        done
);
	import odo_pkg::*;

	logic [63:0] n_q;
	logic [31:0] d_q;
	logic [33:0] r_q;
	logic [63:0] q_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] r_w;
	logic [63:0] n_w;
	logic [1:0]  bits_w;

	assign q    = q_q;
	assign done = done_q;

	// Two dependent compare and subtract steps
	always_comb begin
		r_w    = r_q;
		n_w    = n_q;
		bits_w = 2'b00;
		for (int k = 0; k < 2; k++) begin
			r_w = {r_w[32:0], n_w[63]};
			n_w = {n_w[62:0], 1'b0};
			if (r_w >= {2'b00, d_q}) begin
				r_w = r_w - {2'b00, d_q};
				bits_w[1 - k] = 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			d_q <= d;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= n_w;
			r_q <= r_w;
			q_q <= {q_q[61:0], bits_w};
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

### rtl/odo_cordic.sv
// Iterative rotation CORDIC giving Q30 sine and cosine, one step per cycle.
module odo_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] z,
	output logic signed [33:0] c,
	output logic signed [33:0] s,
	output logic               done
);
	import odo_pkg::*;

	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [33:0] z_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic               done_q;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [33:0] at;

	assign c    = x_q;
	assign s    = y_q;
	assign done = done_q;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed({2'b00, ATAN_Q30[i_q]});

	// Rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CORDIC_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

### rtl/odo_back.sv
// Back end: sequences scaling, arc step, heading rotation and accumulation per item.
module odo_back (
	input  logic               clk,
	input  logic               arst_n,
	input  odo_pkg::odo_cfg_t  cfg,
	input  logic               q_valid,
	input  odo_pkg::odo_item_t q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output odo_pkg::odo_out_t  out_data
);
	import odo_pkg::*;

	odo_state_t         state_q;
	odo_state_t         state_n;
	odo_item_t          it_q;
	logic signed [67:0] prod_q;
	logic signed [67:0] acc_q;
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [31:0] par_in_q;
	logic signed [31:0] perp_in_q;
	logic signed [31:0] lx_q;
	logic signed [31:0] ly_q;
	logic signed [33:0] half_q;
	logic signed [33:0] sn_q;
	logic signed [33:0] ratio_q;
	logic signed [33:0] hc_q;
	logic signed [33:0] hs_q;
	logic               sgn_q;
	logic               flip_q;
	logic [13:0]        frac_q;
	logic [31:0]        disp_x_q;
	logic [31:0]        disp_y_q;
	logic               out_valid_q;
	odo_out_t           out_q;
	logic               div_start;
	logic [63:0]        div_n;
	logic [31:0]        div_d;
	logic [63:0]        div_q;
	logic               div_done;
	logic               cor_start;
	logic signed [33:0] cor_z;
	logic signed [33:0] cor_c;
	logic signed [33:0] cor_s;
	logic               cor_done;
	logic signed [33:0] qs_w;
	logic signed [15:0] h_fold;
	logic               flip_w;
	logic [15:0]        dh_abs;
	logic [15:0]        hf_abs;
	logic [15:0]        ang2;
	logic [28:0]        rec_x;
	logic [31:0]        ang_mag;
	logic               ang_neg;
	logic signed [33:0] ang_w;
	logic [33:0]        half_abs;
	logic               out_free;
	logic signed [67:0] gx_w;
	logic signed [67:0] gy_w;

	odo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.q      (div_q),
		.done   (div_done)
	);

	odo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.z      (cor_z),
		.c      (cor_c),
		.s      (cor_s),
		.done   (cor_done)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign half_abs  = abs34(half_q);

	// Signed quotient, heading folded into the right half plane, angle scaling
	always_comb begin
		qs_w = sgn_q ? -$signed(div_q[33:0]) : $signed(div_q[33:0]);
		if (it_q.head > 16'sd9000) begin
			h_fold = it_q.head - 16'sd18000;
			flip_w = 1'b1;
		end else if (it_q.head < -16'sd9000) begin
			h_fold = it_q.head + 16'sd18000;
			flip_w = 1'b1;
		end else begin
			h_fold = it_q.head;
			flip_w = 1'b0;
		end
		dh_abs  = it_q.dh[15] ? 16'(-it_q.dh) : 16'(it_q.dh);
		hf_abs  = h_fold[15] ? 16'(-h_fold) : 16'(h_fold);
		ang2    = {hf_abs[14:0], 1'b0};
		rec_x   = prod_q[28:0] + ANG_RND;
		ang_mag = prod_q[31:0] + {18'd0, frac_q};
		ang_neg = (state_q == ST_HSTART) ? it_q.dh[15] : h_fold[15];
		ang_w   = ang_neg ? -$signed({2'b00, ang_mag}) : $signed({2'b00, ang_mag});
		gx_w = rnd_shift(acc_q + prod_q, 30);
		gy_w = rnd_shift(acc_q - prod_q, 30);
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (q_valid) state_n = ST_PAR;
			ST_PAR:    state_n = ST_PERP;
			ST_PERP:   state_n = ST_HREM;
			ST_HREM:   state_n = ST_HREC;
			ST_HREC:   state_n = it_q.turn ? ST_HWHOLE : ST_AREM;
			ST_HWHOLE: state_n = ST_HSTART;
			ST_HSTART: state_n = ST_HCOR;
			ST_HCOR:   if (cor_done) state_n = ST_RWAIT;
			ST_RWAIT:  if (div_done) state_n = ST_M1;
			ST_M1:     state_n = ST_M2;
			ST_M2:     state_n = ST_M3;
			ST_M3:     state_n = ST_M4;
			ST_M4:     state_n = ST_M5;
			ST_M5:     state_n = ST_AREM;
			ST_AREM:   state_n = ST_AREC;
			ST_AREC:   state_n = ST_AWHOLE;
			ST_AWHOLE: state_n = ST_ASTART;
			ST_ASTART: state_n = ST_ACOR;
			ST_ACOR:   if (cor_done) state_n = ST_R1;
			ST_R1:     state_n = ST_R2;
			ST_R2:     state_n = ST_R3;
			ST_R3:     state_n = ST_R4;
			ST_R4:     state_n = ST_R5;
			ST_R5:     state_n = ST_OUT;
			ST_OUT:    if (out_free) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// Operand selection and unit starts
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		cor_start = 1'b0;
		cor_z     = '0;
		q_pop     = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_PAR: begin
				mul_a = {{2{it_q.d_par[31]}}, it_q.d_par};
				mul_b = {10'd0, cfg.parallel_scale};
			end
			ST_PERP: begin
				mul_a = {{2{it_q.d_perp[31]}}, it_q.d_perp};
				mul_b = {10'd0, cfg.perp_scale};
			end
			ST_HREM: begin
				mul_a = {18'd0, dh_abs};
				mul_b = ANG_R;
			end
			ST_HREC: begin
				mul_a = {5'd0, rec_x};
				mul_b = ANG_M;
			end
			ST_HWHOLE: begin
				mul_a = {18'd0, dh_abs};
				mul_b = ANG_Q;
			end
			ST_HSTART: begin
				cor_start = 1'b1;
				cor_z     = ang_w;
			end
			ST_HCOR: begin
				div_start = cor_done;
				div_n     = 64'(abs34(cor_s)) << 30;
				div_d     = half_abs[31:0];
			end
			ST_M1: begin
				mul_a = {{2{perp_in_q[31]}}, perp_in_q};
				mul_b = ratio_q;
			end
			ST_M2: begin
				mul_a = {10'd0, cfg.perp_offset, 1'b0};
				mul_b = sn_q;
			end
			ST_M3: begin
				mul_a = {{2{par_in_q[31]}}, par_in_q};
				mul_b = ratio_q;
			end
			ST_M4: begin
				mul_a = {10'd0, cfg.parallel_offset, 1'b0};
				mul_b = sn_q;
			end
			ST_AREM: begin
				mul_a = {18'd0, ang2};
				mul_b = ANG_R;
			end
			ST_AREC: begin
				mul_a = {5'd0, rec_x};
				mul_b = ANG_M;
			end
			ST_AWHOLE: begin
				mul_a = {18'd0, ang2};
				mul_b = ANG_Q;
			end
			ST_ASTART: begin
				cor_start = 1'b1;
				cor_z     = ang_w;
			end
			ST_R1: begin
				mul_a = {{2{lx_q[31]}}, lx_q};
				mul_b = hc_q;
			end
			ST_R2: begin
				mul_a = {{2{ly_q[31]}}, ly_q};
				mul_b = hs_q;
			end
			ST_R3: begin
				mul_a = {{2{ly_q[31]}}, ly_q};
				mul_b = hc_q;
			end
			ST_R4: begin
				mul_a = {{2{lx_q[31]}}, lx_q};
				mul_b = hs_q;
			end
			default: begin
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: if (q_valid) it_q <= q_item;
			ST_PERP: par_in_q <= sat32(rnd_shift(prod_q, 8));
			ST_HREM: perp_in_q <= sat32(rnd_shift(prod_q, 8));
			ST_HREC: begin
				if (!it_q.turn) begin
					lx_q <= perp_in_q;
					ly_q <= par_in_q;
				end
			end
			ST_HWHOLE: frac_q <= prod_q[58:45];
			ST_HSTART: half_q <= ang_w;
			ST_HCOR: begin
				if (cor_done) begin
					sn_q  <= cor_s;
					sgn_q <= cor_s[33] ^ half_q[33];
				end
			end
			ST_RWAIT:  if (div_done) ratio_q <= qs_w;
			ST_M2:     acc_q <= prod_q;
			ST_M3:     lx_q <= sat32(rnd_shift(acc_q + prod_q, 30));
			ST_M4:     acc_q <= prod_q;
			ST_M5:     ly_q <= sat32(rnd_shift(acc_q + prod_q, 30));
			ST_AREM:   flip_q <= flip_w;
			ST_AWHOLE: frac_q <= prod_q[58:45];
			ST_ACOR: begin
				if (cor_done) begin
					hc_q <= flip_q ? -cor_c : cor_c;
					hs_q <= flip_q ? -cor_s : cor_s;
				end
			end
			ST_R2: acc_q <= prod_q;
			ST_R4: acc_q <= prod_q;
			ST_OUT: begin
				if (out_free) begin
					out_q.pos_x       <= $signed(cfg.start_x + disp_x_q);
					out_q.pos_y       <= $signed(cfg.start_y + disp_y_q);
					out_q.heading_out <= it_q.head;
				end
			end
			default: begin
			end
		endcase
	end

	// State, displacement and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			disp_x_q    <= '0;
			disp_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_R3) begin
				disp_x_q <= disp_x_q + gx_w[31:0];
			end
			if (state_q == ST_R5) begin
				disp_y_q <= disp_y_q + gy_w[31:0];
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### tb/sv/odo_pose_checker.sv
// Pose checker: watches the odometry channels, predicts each pose and compares it.
module odo_pose_checker
	import odo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  odo_in_t    in_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  odo_out_t   out_data,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int         errors,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint PI_FX = 64'sd3373259426;
	localparam longint GAIN_FX = 64'sd652032874;
	localparam longint ATAN_FX [32] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1, 0
	};

	// configuration copy
	longint org_x, org_y, head_ofs, par_scale, perp_scale, par_ofs, perp_ofs;
	// tracked state
	logic [31:0] last_par, last_perp, walk_x, walk_y;
	longint      last_gyro;
	odo_out_t    expected_pose[$];

	function automatic longint round_shift(input longint v, input int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint div_half_away(input longint n, input longint d);
		if (n < 0)
			return -((-n + d / 2) / d);
		return (n + d / 2) / d;
	endfunction

	function automatic longint wrap_centideg(input longint v);
		longint r;
		r = v % 36000;
		if (r < 0)
			r += 36000;
		if (r >= 18000)
			r -= 36000;
		return r;
	endfunction

	function automatic void rotate_unit(input longint ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = GAIN_FX;
		y = 0;
		z = ang;
		for (int i = 0; i < CORDIC_ITERS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_FX[i];
			end else begin
				x += dx; y -= dy; z += ATAN_FX[i];
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint wheel_inches(input logic [31:0] now, input logic [31:0] prev,
		input longint scale);
		logic signed [31:0] d;
		d = now - prev;
		return clamp32(round_shift(longint'(d) * scale, 8));
	endfunction

	// Advance the tracked state by one sample and return the pose it yields
	function automatic odo_out_t predict_pose(input odo_in_t s);
		longint g, par_in, perp_in, dh, head, lx, ly, h, hc, hs, gx, gy;
		longint half, sc, sn, ratio;
		logic   flip;
		odo_out_t p;
		g = longint'(s.gyro_heading) % 36000;
		par_in = wheel_inches(s.parallel_ticks, last_par, par_scale);
		perp_in = wheel_inches(s.perp_ticks, last_perp, perp_scale);
		dh = wrap_centideg(g - last_gyro);
		head = wrap_centideg(g + head_ofs);
		flip = 1'b0;
		if (dh == 0) begin
			lx = perp_in;
			ly = par_in;
		end else begin
			half = div_half_away(dh * PI_FX, 36000);
			rotate_unit(half, sc, sn);
			ratio = (sn * (64'sd1 <<< 30)) / half;
			lx = clamp32(round_shift(perp_in * ratio + 2 * perp_ofs * sn, 30));
			ly = clamp32(round_shift(par_in * ratio + 2 * par_ofs * sn, 30));
		end
		// fold the heading into +-90 degrees for the rotation
		h = head;
		if (h > 9000) begin
			h -= 18000; flip = 1'b1;
		end else if (h < -9000) begin
			h += 18000; flip = 1'b1;
		end
		rotate_unit(div_half_away(h * PI_FX, 18000), hc, hs);
		if (flip) begin
			hc = -hc; hs = -hs;
		end
		gx = round_shift(lx * hc + ly * hs, 30);
		gy = round_shift(ly * hc - lx * hs, 30);
		walk_x += gx[31:0];
		walk_y += gy[31:0];
		last_par = s.parallel_ticks;
		last_perp = s.perp_ticks;
		last_gyro = g;
		p.pos_x = org_x[31:0] + walk_x;
		p.pos_y = org_y[31:0] + walk_y;
		p.heading_out = head[15:0];
		return p;
	endfunction

	assign pending = expected_pose.size();

	// Track config, predict accepted items, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		odo_out_t e;
		if (!arst_n) begin
			org_x = 0; org_y = 0; head_ofs = 0;
			par_scale = 475825; perp_scale = 406287;
			par_ofs = 360448; perp_ofs = 327680;
			last_par = '0; last_perp = '0; last_gyro = 0;
			walk_x = '0; walk_y = '0;
			expected_pose.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_X:         org_x = longint'(signed'(cfg_data));
					CFG_START_Y:         org_y = longint'(signed'(cfg_data));
					CFG_START_HEADING:   head_ofs = longint'(signed'(cfg_data[15:0]));
					CFG_PARALLEL_SCALE:  par_scale = longint'(cfg_data[23:0]);
					CFG_PERP_SCALE:      perp_scale = longint'(cfg_data[23:0]);
					CFG_PARALLEL_OFFSET: par_ofs = longint'(cfg_data[22:0]);
					CFG_PERP_OFFSET:     perp_ofs = longint'(cfg_data[22:0]);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_pose.size() == 0) begin
					$display("%t: unexpected pose %h", $time, out_data);
					errors++;
				end else begin
					e = expected_pose.pop_front();
					if (out_data.pos_x !== e.pos_x) begin
						$display("%t: pos_x expected %h actual %h", $time, e.pos_x, out_data.pos_x);
						errors++;
					end
					if (out_data.pos_y !== e.pos_y) begin
						$display("%t: pos_y expected %h actual %h", $time, e.pos_y, out_data.pos_y);
						errors++;
					end
					if (out_data.heading_out !== e.heading_out) begin
						$display("%t: heading_out expected %0d actual %0d", $time,
							e.heading_out, out_data.heading_out);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_pose.push_back(predict_pose(in_data));
		end
	end

endmodule

### tb/sv/tracking_wheel_odometry_top_test.sv
// Testbench top for the tracking wheel odometry block: stimulus, config phases and verdict.
module tracking_wheel_odometry_top_test;
	import odo_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 200;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	odo_in_t    in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	odo_out_t   out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = CFG_START_X;
	logic [31:0] cfg_data = '0;
	int         errors, pending;

	bit         no_idle = 1'b0;
	int         hold_reqs = 0, holds_done = 0, hold_cnt = 0, quiet_cycles = 0;
	logic [31:0] cur_par = '0, cur_perp = '0;
	int         cur_gyro = 0;

	tracking_wheel_odometry_top uut (.*);
	odo_pose_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stall, long hold-off on request
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall = 1'b1;
		end else if (hold_reqs != holds_done) begin
			holds_done++;
			hold_cnt = HOLD_CYCLES;
			out_stall = 1'b1;
		end else begin
			out_stall = !no_idle && ($urandom_range(99) < 10);
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else if (arst_n && ++quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [31:0] par, input logic [31:0] perp,
		input logic [15:0] gyro);
		in_data = '{parallel_ticks: par, perp_ticks: perp, gyro_heading: gyro};
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 10) begin
			in_valid = 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] d);
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(input logic [31:0] sx, input logic [31:0] sy,
		input logic [15:0] sh, input logic [23:0] ps, input logic [23:0] qs,
		input logic [22:0] po, input logic [22:0] qo);
		drain();
		write_reg(CFG_START_X, sx);
		write_reg(CFG_START_Y, sy);
		write_reg(CFG_START_HEADING, {{16{sh[15]}}, sh});
		write_reg(CFG_PARALLEL_SCALE, {8'd0, ps});
		write_reg(CFG_PERP_SCALE, {8'd0, qs});
		write_reg(CFG_PARALLEL_OFFSET, {9'd0, po});
		write_reg(CFG_PERP_OFFSET, {9'd0, qo});
	endtask

	// Mostly smooth motion; some samples are full-range noise
	task automatic send_random();
		if ($urandom_range(99) < 85) begin
			cur_par += 32'($urandom_range(4000)) - 32'd2000;
			cur_perp += 32'($urandom_range(4000)) - 32'd2000;
			if ($urandom_range(99) >= 20)
				cur_gyro = (cur_gyro + 36000 + $urandom_range(1200) - 600) % 36000;
		end else begin
			cur_par = $urandom;
			cur_perp = $urandom;
			cur_gyro = $urandom_range(65535);
		end
		send_item(cur_par, cur_perp, 16'(cur_gyro));
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: first step from zero, extremes, wrap crossings, out-of-range gyro
		send_item(32'd0, 32'd0, 16'd0);
		send_item(32'd360, 32'd100, 16'd0);
		send_item(32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
		send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'd100);
		send_item(32'd0, 32'd0, 16'd35999);
		send_item(32'd50, 32'd50, 16'd1);
		send_item(32'd50, 32'd50, 16'd35990);
		send_item(32'd400, 32'd20, 16'd18000);
		send_item(32'd400, 32'd20, 16'd18000);
		send_item(32'd800, 32'd0, 16'd0);
		send_item(32'd900, 32'd40, 16'd9000);
		send_item(32'd1000, 32'd80, 16'd27000);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd36000);
		send_item(32'h0000_0001, 32'h0000_0001, 16'hFFFF);
		send_item(32'd0, 32'd0, 16'd0);
		send_item(32'd100, 32'd0, 16'd17999);
		send_item(32'd200, 32'd0, 16'd18001);
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 16'sd18000, 24'hFFFFFF, 24'hFFFFFF,
			23'd4194304, 23'd4194304);
		send_item(32'h7FFF_0000, 32'h8000_FFFF, 16'd20000);
		send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'd20000);
		send_item(32'd0, 32'd0, 16'd100);
		write_all(32'd0, 32'd0, -16'sd18000, 24'd0, 24'd0, 23'h7FFFFF, 23'h7FFFFF);
		send_item(32'd12345, 32'd999, 16'd500);
		send_item(32'd22345, 32'd1999, 16'd800);

		// random phases under different settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_all(32'd0, 32'd0, 16'sd0, 24'd475825, 24'd406287,
					23'd360448, 23'd327680);
				1: write_all(32'h7FFF_FFFF, 32'h8000_0000, 16'sd18000, 24'hFFFFFF,
					24'hFFFFFF, 23'd4194304, 23'd4194304);
				2: write_all(32'h8000_0000, 32'h7FFF_FFFF, -16'sd18000, 24'd0, 24'd0,
					23'd0, 23'd0);
				3: write_all($urandom, $urandom, 16'($urandom_range(36000) - 18000),
					24'($urandom), 24'($urandom), 23'($urandom_range(4194304)),
					23'($urandom_range(4194304)));
				default: write_all($urandom, $urandom, 16'($urandom), 24'($urandom),
					24'($urandom), 23'h7FFFFF, 23'($urandom));
			endcase
			no_idle = (ph == 3);
			for (int n = 0; n < 250; n++) begin
				if (ph == 1 && n == 50)
					hold_reqs++;
				if (ph == 1 && n == 150) begin
					in_valid = 1'b0;
					while (pending != 0) @(negedge clk);
				end
				send_random();
			end
		end
		no_idle = 1'b0;

		drain();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
